>>> src/obst_pkg.sv
// shared constants, types and the table address map of the optimal bst cost table
`default_nettype none

package obst_pkg;

   localparam int MAX_KEYS    = 64;
   localparam int WEIGHT_BITS = 16;

   // fixed field widths of the ports
   localparam int WEIGHT_PORT_BITS = 16;
   localparam int INDEX_PORT_BITS  = 7;
   localparam int COST_BITS        = 32;
   localparam int ROOT_BITS        = 7;

   // key indexes run 0..MAX_KEYS+1, the key count 0..MAX_KEYS
   localparam int IDX_BITS   = $clog2(MAX_KEYS + 2);
   localparam int CNT_BITS   = $clog2(MAX_KEYS + 1);
   localparam int WADDR_BITS = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

   // table rows 1..MAX_KEYS+1, columns 0..MAX_KEYS
   localparam int TBL_DIM     = MAX_KEYS + 1;
   localparam int TBL_DEPTH   = TBL_DIM * TBL_DIM;
   localparam int TADDR_BITS  = $clog2(TBL_DEPTH);

   localparam int SUM_BITS  = WEIGHT_BITS + $clog2(MAX_KEYS + 1);
   localparam int PAIR_BITS = COST_BITS + 1;
   localparam int TOT_BITS  = ((PAIR_BITS > SUM_BITS) ? PAIR_BITS : SUM_BITS) + 1;
   localparam int CMP_BITS  = ((INDEX_PORT_BITS > CNT_BITS) ? INDEX_PORT_BITS : CNT_BITS) + 1;

   localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef logic [COST_BITS-1:0]   cost_type;
   typedef logic [ROOT_BITS-1:0]   root_type;
   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef logic [TADDR_BITS-1:0]  taddr_type;
   typedef logic [WADDR_BITS-1:0]  waddr_type;

   typedef struct packed {
      root_type root;
      cost_type cost;
   } entry_type;

   // one candidate root in flight between table read and compare
   typedef struct packed {
      logic    valid;
      logic    first;    // k == i, left subtree empty, starts the cell
      logic    r_empty;  // k == j, right subtree empty
      idx_type k;
   } cand_type;

   function automatic taddr_type tbl_addr(input idx_type r, input idx_type c);
      taddr_type rr;
      taddr_type cc;
      rr = taddr_type'(r) - taddr_type'(1);
      cc = taddr_type'(c);
      return rr * taddr_type'(TBL_DIM) + cc;
   endfunction

endpackage

`default_nettype wire

>>> src/optimal_bst_cost_table.sv
// top level of the optimal binary search tree cost table: handshakes and fill sequencer
//
// req channel: operation 0 appends one key weight (last = 1 closes the set and
// starts the table fill), operation 1 reads the cost and root of entry row..col.
// rsp channel: one word per read and one word per finished fill; appends
// without last give no word.
// appends are taken one per cycle. reads are taken one per cycle too; their word
// goes through the table read register into the rsp register, and a new item is taken
// in the cycle that word leaves toward a free or unstalled rsp register.
// the fill walks the table one diagonal at a time; each cell i..j reads one
// candidate root per cycle from the two-port table memory in ST_FILL_RD, waits in
// ST_FILL_WAIT for the last read data and writes the cell in ST_FILL_WR; after the
// last cell, ST_FILL_OUT moves the total cost word into the rsp register.
// req_stall is high during a fill and while a finished word cannot move into a
// stalled rsp register. reset empties the key set and marks the table unfilled;
// reads then return status 1 until the next fill completes.
`default_nettype none

module optimal_bst_cost_table (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire                                       req_operation,
   input  wire  [obst_pkg::WEIGHT_PORT_BITS-1:0]     req_weight,
   input  wire                                       req_last,
   input  wire  [obst_pkg::INDEX_PORT_BITS-1:0]      req_row,
   input  wire  [obst_pkg::INDEX_PORT_BITS-1:0]      req_col,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic [obst_pkg::COST_BITS-1:0]            rsp_cost,
   output logic [obst_pkg::ROOT_BITS-1:0]            rsp_root,
   output logic                                      rsp_status
);
   import obst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_OUT,
      ST_FILL_RD,
      ST_FILL_WAIT,
      ST_FILL_WR,
      ST_FILL_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    filled_ff, filled_in;
   idx_type                 d_ff, d_in;
   idx_type                 i_ff, i_in;
   idx_type                 j_ff, j_in;
   idx_type                 k_ff, k_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic                    rd_empty_ff, rd_empty_in;
   entry_type               fin_ff, fin_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cost_type                rsp_cost_ff, rsp_cost_in;
   root_type                rsp_root_ff, rsp_root_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    req_acc;
   logic                    out_free;
   logic [CNT_BITS-1:0]     base;
   logic [CMP_BITS-1:0]     row_c, col_c, n_c;
   logic                    in_range;
   idx_type                 n_idx;

   logic                    tbl_we;
   taddr_type               tbl_waddr;
   logic                    tbl_a_en, tbl_b_en;
   taddr_type               tbl_a_addr, tbl_b_addr;
   entry_type               tbl_a_data, tbl_b_data;
   logic                    w_we, w_re;
   waddr_type               w_waddr, w_raddr;
   weight_type              w_rdata;
   cand_type                cand;
   entry_type               cell_result;

   obst_table_mem u_table (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (tbl_waddr),
      .wr_data   (cell_result),
      .rd_a_en   (tbl_a_en),
      .rd_a_addr (tbl_a_addr),
      .rd_a_data (tbl_a_data),
      .rd_b_en   (tbl_b_en),
      .rd_b_addr (tbl_b_addr),
      .rd_b_data (tbl_b_data)
   );

   obst_weight_mem u_weights (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (weight_type'(req_weight)),
      .rd_en   (w_re),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   obst_cell_min u_cell (
      .clock  (clock),
      .reset  (reset),
      .cand   (cand),
      .l_cost (tbl_a_data.cost),
      .r_cost (tbl_b_data.cost),
      .weight (w_rdata),
      .cell_i (i_ff),
      .result (cell_result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_READ_OUT) && out_free));
   assign req_acc   = req_valid && !req_stall;

   // entry range check for reads
   assign row_c    = CMP_BITS'(req_row);
   assign col_c    = CMP_BITS'(req_col);
   assign n_c      = CMP_BITS'(count_ff);
   assign in_range = filled_ff && (row_c != '0) && (row_c <= n_c + CMP_BITS'(1)) &&
                     (col_c + CMP_BITS'(1) >= row_c) && (col_c <= n_c);

   // an append after a fill starts a new set
   assign base  = filled_ff ? '0 : count_ff;
   assign n_idx = idx_type'(count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      filled_in     = filled_ff;
      d_in          = d_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      rd_ok_in      = rd_ok_ff;
      rd_empty_in   = rd_empty_ff;
      fin_in        = fin_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_status_in = rsp_status_ff;

      tbl_we     = 1'b0;
      tbl_waddr  = tbl_addr(i_ff, j_ff);
      tbl_a_en   = 1'b0;
      tbl_a_addr = tbl_addr(i_ff, k_ff - idx_type'(1));
      tbl_b_en   = 1'b0;
      tbl_b_addr = tbl_addr(k_ff + idx_type'(1), j_ff);
      w_we       = 1'b0;
      w_waddr    = waddr_type'(base);
      w_re       = 1'b0;
      w_raddr    = waddr_type'(k_ff - idx_type'(1));
      cand       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE, ST_READ_OUT: begin
            if ((state_ff == ST_READ_OUT) && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cost_in   = (rd_ok_ff && !rd_empty_ff) ? tbl_a_data.cost : '0;
               rsp_root_in   = (rd_ok_ff && !rd_empty_ff) ? tbl_a_data.root : '0;
               rsp_status_in = rd_ok_ff ? STATUS_OK : STATUS_RANGE;
               state_in      = ST_IDLE;
            end
            if (req_acc) begin
               if (req_operation == OP_READ) begin
                  tbl_a_en    = 1'b1;
                  tbl_a_addr  = tbl_addr(idx_type'(req_row), idx_type'(req_col));
                  rd_ok_in    = in_range;
                  rd_empty_in = (col_c + CMP_BITS'(1) == row_c);
                  state_in    = ST_READ_OUT;
               end else begin
                  filled_in = 1'b0;
                  if (base < CNT_BITS'(MAX_KEYS)) begin
                     w_we     = 1'b1;
                     count_in = base + CNT_BITS'(1);
                  end else begin
                     count_in = base;
                  end
                  if (req_last) begin
                     d_in     = '0;
                     i_in     = idx_type'(1);
                     j_in     = idx_type'(1);
                     k_in     = idx_type'(1);
                     state_in = ST_FILL_RD;
                  end
               end
            end
         end
         ST_FILL_RD: begin
            // one candidate root per cycle: left subtree, right subtree, weight of k
            tbl_a_en     = 1'b1;
            tbl_b_en     = 1'b1;
            w_re         = 1'b1;
            cand.valid   = 1'b1;
            cand.first   = (k_ff == i_ff);
            cand.r_empty = (k_ff == j_ff);
            cand.k       = k_ff;
            if (k_ff == j_ff) begin
               state_in = ST_FILL_WAIT;
            end else begin
               k_in = k_ff + idx_type'(1);
            end
         end
         ST_FILL_WAIT: begin
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            tbl_we = 1'b1;
            if (j_ff == n_idx) begin
               if (i_ff == idx_type'(1)) begin
                  fin_in   = cell_result;
                  state_in = ST_FILL_OUT;
               end else begin
                  d_in     = d_ff + idx_type'(1);
                  i_in     = idx_type'(1);
                  j_in     = d_ff + idx_type'(2);
                  k_in     = idx_type'(1);
                  state_in = ST_FILL_RD;
               end
            end else begin
               i_in     = i_ff + idx_type'(1);
               j_in     = j_ff + idx_type'(1);
               k_in     = i_ff + idx_type'(1);
               state_in = ST_FILL_RD;
            end
         end
         ST_FILL_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cost_in   = fin_ff.cost;
               rsp_root_in   = fin_ff.root;
               rsp_status_in = STATUS_OK;
               filled_in     = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff          <= d_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      rd_ok_ff      <= rd_ok_in;
      rd_empty_ff   <= rd_empty_in;
      fin_ff        <= fin_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cost   = rsp_cost_ff;
   assign rsp_root   = rsp_root_ff;
   assign rsp_status = rsp_status_ff;

   // a cell is written only in a cycle with no table read, so no forwarding is needed
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(tbl_we && (tbl_a_en || tbl_b_en)))
      else $error("table write overlaps a table read");

   a_fill_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_operation == OP_APPEND) && req_last) |=>
      ((state_ff == ST_FILL_RD) && (i_ff == idx_type'(1)) && (k_ff == idx_type'(1))))
      else $error("last weight did not start the fill");

   a_root_in_cell: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL_RD) |-> ((k_ff >= i_ff) && (k_ff <= j_ff) && (j_ff <= n_idx)))
      else $error("candidate root outside the cell");

   a_filled_after_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(filled_ff) |-> ($past(state_ff) == ST_FILL_OUT))
      else $error("table marked filled without a finished fill");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_KEYS))
      else $error("key count beyond the store");

endmodule

`default_nettype wire

>>> src/obst_table_mem.sv
// cost and root table memory, one write port and two registered read ports
`default_nettype none

module obst_table_mem (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire obst_pkg::taddr_type   wr_addr,
   input  wire obst_pkg::entry_type   wr_data,
   input  wire                        rd_a_en,
   input  wire obst_pkg::taddr_type   rd_a_addr,
   output obst_pkg::entry_type        rd_a_data,
   input  wire                        rd_b_en,
   input  wire obst_pkg::taddr_type   rd_b_addr,
   output obst_pkg::entry_type        rd_b_data
);
   import obst_pkg::*;

   entry_type mem_ff [TBL_DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

>>> src/obst_weight_mem.sv
// key weight store, one write port and one registered read port
`default_nettype none

module obst_weight_mem (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire obst_pkg::waddr_type   wr_addr,
   input  wire obst_pkg::weight_type  wr_data,
   input  wire                        rd_en,
   input  wire obst_pkg::waddr_type   rd_addr,
   output obst_pkg::weight_type       rd_data
);
   import obst_pkg::*;

   weight_type mem_ff [MAX_KEYS];
   weight_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

>>> src/obst_cell_min.sv
// running minimum over candidate roots of one table cell, plus weight sum and saturation
`default_nettype none

module obst_cell_min (
   input  wire                        clock,
   input  wire                        reset,
   input  wire obst_pkg::cand_type    cand,
   input  wire obst_pkg::cost_type    l_cost,
   input  wire obst_pkg::cost_type    r_cost,
   input  wire obst_pkg::weight_type  weight,
   input  wire obst_pkg::idx_type     cell_i,
   output obst_pkg::entry_type        result
);
   import obst_pkg::*;

   cand_type                cand_ff;
   logic [PAIR_BITS-1:0]    best_ff, best_in;
   idx_type                 best_k_ff, best_k_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;

   cost_type                l_val;
   cost_type                r_val;
   logic [PAIR_BITS-1:0]    pair;
   logic [TOT_BITS-1:0]     total;
   logic                    sat;

   // cand_ff lines up with the table and weight read data
   always_comb begin
      l_val     = cand_ff.first   ? '0 : l_cost;
      r_val     = cand_ff.r_empty ? '0 : r_cost;
      pair      = PAIR_BITS'(l_val) + PAIR_BITS'(r_val);
      best_in   = best_ff;
      best_k_in = best_k_ff;
      sum_in    = sum_ff;
      if (cand_ff.valid) begin
         // strict compare keeps the smallest minimizing root
         if (cand_ff.first || (pair < best_ff)) begin
            best_in   = pair;
            best_k_in = cand_ff.k;
         end
         sum_in = cand_ff.first ? SUM_BITS'(weight) : sum_ff + SUM_BITS'(weight);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand;
      end
      best_ff   <= best_in;
      best_k_ff <= best_k_in;
      sum_ff    <= sum_in;
   end

   // a saturated minimum is reached by every root, so the first one wins
   always_comb begin
      total       = TOT_BITS'(best_ff) + TOT_BITS'(sum_ff);
      sat         = total > TOT_BITS'(COST_MAX);
      result.cost = sat ? COST_MAX : total[COST_BITS-1:0];
      result.root = sat ? ROOT_BITS'(cell_i) : ROOT_BITS'(best_k_ff);
   end

endmodule

`default_nettype wire
